### hdl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants of the fair share slot scheduler
// request and slot codes, item structs, chain token and cell command types
// ----------------------------------------------------------------------------
package fss_pkg;

  // table depth default and register reset value
  localparam int unsigned MAX_PROCS_DEF  = 16;
  localparam logic [7:0]  BASE_SLICE_RST = 8'd4;

  // saturation limits
  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
  localparam logic [31:0] VT_MAX   = 32'hFFFFFFFF;

  // divider: 9-bit numerator, one quotient bit per step
  localparam int unsigned DIV_NUM_W = 9;
  localparam logic [3:0]  DIV_STEPS = 4'd9;

  typedef enum logic [1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_FULL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  slot_kind;
    logic [3:0]  proc_index;
    logic [15:0] length;
    logic        finished;
    logic [23:0] turnaround;
    logic [23:0] waiting;
  } out_item_t;

  // best-so-far record handed from cell to cell
  typedef struct packed {
    logic        rdy;
    logic [31:0] vt;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] rem;
    logic [7:0]  wt;
    logic        pend;
    logic [15:0] next_arr;
  } token_t;

  // write and update command broadcast to the cells
  typedef struct packed {
    logic        wr_en;
    logic        upd_en;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  weight;
    logic [15:0] new_rem;
    logic [31:0] new_vt;
  } cell_cmd_t;

endpackage

### hdl/fss_cell.sv
// ----------------------------------------------------------------------------
// fss_cell: one process entry of the scheduler chain
// holds one table entry and merges it into the best-so-far token each cycle
// ----------------------------------------------------------------------------
module fss_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fss_pkg::cell_cmd_t cmd_i,
  input  logic [IDX_W-1:0]   cmd_idx_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [23:0]        now_i,
  input  fss_pkg::token_t    tok_i,
  input  logic [IDX_W-1:0]   tok_idx_i,
  output fss_pkg::token_t    tok_o,
  output logic [IDX_W-1:0]   tok_idx_o
);
  import fss_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [15:0] arr_q, burst_q, rem_q;
  logic [7:0]  wt_q;
  logic [31:0] vt_q;
  logic        active, rdy_here, pend_here, take_r, take_p;
  token_t      tok_d, tok_q;
  logic [IDX_W-1:0] idx_d, idx_q;

  // entry storage, written on add and on a run slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_idx_i == MY_IDX) begin
      arr_q   <= cmd_i.arrival;
      burst_q <= cmd_i.burst;
      rem_q   <= cmd_i.burst;
      wt_q    <= cmd_i.weight;
      vt_q    <= '0;
    end else if (cmd_i.upd_en && cmd_idx_i == MY_IDX) begin
      rem_q <= cmd_i.new_rem;
      vt_q  <= cmd_i.new_vt;
    end
  end

  // compare own entry against the incoming best
  always_comb begin
    active    = (MY_CNT < count_i) && (rem_q != '0);
    rdy_here  = active && ({8'd0, arr_q} <= now_i);
    pend_here = active && !rdy_here;
    take_r    = rdy_here && (!tok_i.rdy || vt_q < tok_i.vt ||
                             (vt_q == tok_i.vt && arr_q < tok_i.arr));
    take_p    = pend_here && (!tok_i.pend || arr_q < tok_i.next_arr);
    tok_d     = tok_i;
    idx_d     = tok_idx_i;
    if (take_r) begin
      tok_d.rdy   = 1'b1;
      tok_d.vt    = vt_q;
      tok_d.arr   = arr_q;
      tok_d.burst = burst_q;
      tok_d.rem   = rem_q;
      tok_d.wt    = wt_q;
      idx_d       = MY_IDX;
    end
    if (take_p) begin
      tok_d.pend     = 1'b1;
      tok_d.next_arr = arr_q;
    end
  end

  // token register towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      idx_q <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = idx_q;

endmodule

### hdl/fss_div.sv
// ----------------------------------------------------------------------------
// fss_div: iterative restoring divider for the slice length
// one quotient bit per cycle over a 9-bit numerator and 8-bit divisor
// ----------------------------------------------------------------------------
module fss_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fss_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [7:0]                        den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [fss_pkg::DIV_NUM_W-1:0]     quot_o
);
  import fss_pkg::*;

  logic [DIV_NUM_W-1:0] nq_q, nq_d;
  logic [7:0]           r_q, r_d, den_q;
  logic [3:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [8:0]           rs;

  // one restoring step
  always_comb begin
    rs     = {r_q, nq_q[DIV_NUM_W-1]};
    nq_d   = nq_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      nq_d   = num_i;
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rs >= {1'b0, den_q}) begin
        r_d  = 8'(rs - {1'b0, den_q});
        nq_d = {nq_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        r_d  = rs[7:0];
        nq_d = {nq_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == DIV_STEPS - 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q <= nq_d;
    r_q  <= r_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

### hdl/fair_share_slot_scheduler.sv
// ----------------------------------------------------------------------------
// fair_share_slot_scheduler: least virtual runtime slot scheduler
// chain of entry cells scanned per dispatch, iterative slice divider
// ----------------------------------------------------------------------------
// Clear and add requests are done in the idle state, which stays ready; a
// full-table add gives its item from the response state. A dispatch that runs
// a process scans the chain: the best-so-far token walks the chain of
// MAX_PROCS entry cells one cell per cycle, the pick state takes the winner,
// the slice ceil(base/weight) comes from a 9-step shift-subtract divider whose
// quotient is handed over through its registered done flag, and the response
// state writes back the entry, time and result. A dispatch with nothing ready
// skips the divider. The next item is taken in the cycle after the result is
// written. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted, and a later result stalls
// until that register is free. The base slice register is written on its own
// valid/ready channel, which is always ready.
module fair_share_slot_scheduler #(
  parameter int unsigned MAX_PROCS = fss_pkg::MAX_PROCS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fss_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fss_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import fss_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PROCS);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_PROCS - 1);

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [CNT_W-1:0]  count_q, count_d, scan_q, scan_d;
  logic [23:0]       now_q, now_d;
  logic [7:0]        base_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              in_fire, out_free;
  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  cmd_idx;

  token_t            tok [MAX_PROCS+1];
  logic [IDX_W-1:0]  tok_idx [MAX_PROCS+1];
  token_t            best;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W+3:0]  best_idx_ext;

  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, quot;

  logic [15:0] slice;
  logic [16:0] prod;
  logic [32:0] vt_sum;
  logic [24:0] now_sum;
  logic [23:0] now_run, tat;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_SLICE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // cell chain, fed with an empty token
  assign tok[0]     = '0;
  assign tok_idx[0] = '0;
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    fss_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .cmd_idx_i (cmd_idx),
      .count_i   (count_q),
      .now_i     (now_q),
      .tok_i     (tok[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_o     (tok[g+1]),
      .tok_idx_o (tok_idx[g+1])
    );
  end
  assign best         = tok[MAX_PROCS];
  assign best_idx     = tok_idx[MAX_PROCS];
  assign best_idx_ext = {4'd0, best_idx};

  // slice divider
  assign div_start = (state_q == ST_PICK) && best.rdy;
  assign div_num   = DIV_NUM_W'({1'b0, base_q} + {1'b0, best.wt} - 9'd1);

  fss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (best.wt),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // run slot arithmetic
  always_comb begin
    slice = ({7'd0, quot} < best.rem) ? {7'd0, quot} : best.rem;
    if (slice == '0) slice = 16'd1;
    prod    = {8'd0, slice[8:0]} * {9'd0, best.wt};
    vt_sum  = {1'b0, best.vt} + {16'd0, prod};
    now_sum = {1'b0, now_q} + {9'd0, slice};
    now_run = now_sum[24] ? TIME_MAX : now_sum[23:0];
    tat     = now_run - {8'd0, best.arr};
  end

  // sequencer: next state, cell commands and result
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    scan_d      = scan_q;
    now_d       = now_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd         = '0;
    cmd_idx     = count_q[IDX_W-1:0];
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_d = req_e'(in_data_i.req_type);
          unique case (req_e'(in_data_i.req_type))
            REQ_CLEAR: begin
              count_d = '0;
              now_d   = '0;
            end
            REQ_ADD: begin
              if (count_q >= CNT_MAX) begin
                state_d = ST_RESP;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.arrival = in_data_i.arrival;
                cmd.burst   = in_data_i.burst;
                cmd.weight  = (in_data_i.prio == '0) ? 8'd1 : in_data_i.prio;
                count_d     = count_q + CNT_W'(1);
              end
            end
            REQ_DISPATCH: begin
              scan_d  = '0;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + CNT_W'(1);
        if (scan_q == SCAN_END) state_d = ST_PICK;
      end
      ST_PICK: begin
        state_d = best.rdy ? ST_DIV : ST_RESP;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = ST_IDLE;
          if (req_q == REQ_ADD) begin
            out_d.slot_kind = KIND_FULL;
          end else if (best.rdy) begin
            cmd.upd_en       = 1'b1;
            cmd_idx          = best_idx;
            cmd.new_rem      = best.rem - slice;
            cmd.new_vt       = vt_sum[32] ? VT_MAX : vt_sum[31:0];
            now_d            = now_run;
            out_d.slot_kind  = KIND_RUN;
            out_d.proc_index = best_idx_ext[3:0];
            out_d.length     = slice;
            if (best.rem == slice) begin
              out_d.finished   = 1'b1;
              out_d.turnaround = tat;
              out_d.waiting    = (tat >= {8'd0, best.burst}) ?
                                 tat - {8'd0, best.burst} : '0;
            end
          end else if (best.pend) begin
            out_d.slot_kind = KIND_IDLE;
            out_d.length    = best.next_arr - now_q[15:0];
            now_d           = {8'd0, best.next_arr};
          end else begin
            out_d.slot_kind = KIND_DONE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= REQ_NONE;
      count_q     <= '0;
      scan_q      <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // table fill never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count beyond table depth");

  // divider only runs while the sequencer waits on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == ST_DIV)
    else $error("divider busy outside divide state");

  // an accepted dispatch starts the chain scan
  a_dispatch_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.req_type == REQ_DISPATCH) |=> state_q == ST_SCAN)
    else $error("dispatch did not start a scan");

  // an entry update comes only with a run slot result
  a_upd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_en |=> out_valid_q && out_q.slot_kind == KIND_RUN)
    else $error("entry update without run slot item");

endmodule

### dv/tb_fair_share_slot_scheduler.sv
// ----------------------------------------------------------------------------
// tb_fair_share_slot_scheduler: self-checking bench of the slot scheduler
// drives clear, add, dispatch and type-three items with random idling on both
// sides, predicts every slot and compares each output item field by field
// ----------------------------------------------------------------------------
module tb_fair_share_slot_scheduler;
  import fss_pkg::*;

  localparam int unsigned DEPTH = 16;

  // predictor of the slot sequence and store of pending slots
  class slot_board;
    logic [15:0] arr_q[DEPTH];
    logic [15:0] bur_q[DEPTH];
    logic [15:0] rem_q[DEPTH];
    logic [7:0]  wt_q[DEPTH];
    logic [31:0] vt_q[DEPTH];
    int unsigned count;
    logic [23:0] now;
    logic [7:0]  base;
    out_item_t   pending[$];
    int unsigned errors;
    int unsigned n_run, n_idle, n_done, n_full, n_fin;

    function new();
      count = 0; now = 0; base = BASE_SLICE_RST; errors = 0;
      n_run = 0; n_idle = 0; n_done = 0; n_full = 0; n_fin = 0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      bit rdy, pnd;
      int unsigned best, sl, w;
      logic [15:0] nxt;
      longint unsigned vt, tm;
      r = '0; rdy = 0; pnd = 0; best = 0; nxt = 0;
      case (req_e'(it.req_type))
        REQ_CLEAR: begin
          count = 0; now = 0;
        end
        REQ_ADD: begin
          if (count >= DEPTH) begin
            r.slot_kind = KIND_FULL; pending = {pending, r};
          end else begin
            arr_q[count] = it.arrival; bur_q[count] = it.burst;
            rem_q[count] = it.burst;
            wt_q[count] = (it.prio == 0) ? 8'd1 : it.prio;
            vt_q[count] = 0; count++;
          end
        end
        REQ_DISPATCH: begin
          // scan for least virtual time, earliest arrival breaks ties
          for (int i = 0; i < count; i++) begin
            if (rem_q[i] == 0) continue;
            if ({8'd0, arr_q[i]} <= now) begin
              if (!rdy || vt_q[i] < vt_q[best] ||
                  (vt_q[i] == vt_q[best] && arr_q[i] < arr_q[best])) begin
                best = i; rdy = 1;
              end
            end else if (!pnd || arr_q[i] < nxt) begin
              nxt = arr_q[i]; pnd = 1;
            end
          end
          if (rdy) begin
            w = wt_q[best];
            sl = (base + w - 1) / w;
            if (sl > rem_q[best]) sl = rem_q[best];
            if (sl == 0) sl = 1;
            tm = longint'(now) + sl;
            now = (tm > TIME_MAX) ? TIME_MAX : tm[23:0];
            rem_q[best] = rem_q[best] - sl;
            vt = longint'(vt_q[best]) + longint'(sl) * w;
            vt_q[best] = (vt > VT_MAX) ? VT_MAX : vt[31:0];
            r.slot_kind = KIND_RUN; r.proc_index = best[3:0]; r.length = sl[15:0];
            if (rem_q[best] == 0) begin
              r.finished = 1;
              r.turnaround = now - arr_q[best];
              r.waiting = (r.turnaround >= bur_q[best]) ? r.turnaround - bur_q[best] : 0;
            end
          end else if (pnd) begin
            r.slot_kind = KIND_IDLE; r.length = nxt - now[15:0];
            now = {8'd0, nxt};
          end else begin
            r.slot_kind = KIND_DONE;
          end
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected slot %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      case (kind_e'(got.slot_kind))
        KIND_RUN: n_run++;
        KIND_IDLE: n_idle++;
        KIND_DONE: n_done++;
        default: n_full++;
      endcase
      if (got.finished) n_fin++;
      if (got.slot_kind !== e.slot_kind) report("slot_kind", e.slot_kind, got.slot_kind);
      if (got.proc_index !== e.proc_index) report("proc_index", e.proc_index, got.proc_index);
      if (got.length !== e.length) report("length", e.length, got.length);
      if (got.finished !== e.finished) report("finished", e.finished, got.finished);
      if (got.turnaround !== e.turnaround) report("turnaround", e.turnaround, got.turnaround);
      if (got.waiting !== e.waiting) report("waiting", e.waiting, got.waiting);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, f, e, g);
      errors++;
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [7:0] cfg_data_i;
  in_item_t in_data_i;
  out_item_t out_data_o;

  slot_board board;
  bit calm;        // no idling on either side
  int unsigned hold_off;

  fair_share_slot_scheduler u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // send one item, with a random idle gap first; valid stays up afterwards
  task automatic send_item(input logic [1:0] rt, input logic [15:0] a,
                           input logic [15:0] b, input logic [7:0] p);
    in_item_t it;
    it = '{req_type: rt, arrival: a, burst: b, prio: p};
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(it);
  endtask

  // wait until the block is quiet, then write the base slice
  task automatic write_base(input logic [7:0] v);
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1; cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.base = v;
    cfg_valid_i <= 0;
  endtask

  // one random table load followed by dispatches, with some adds and type-three items
  task automatic run_set(input int unsigned n, input bit wide);
    logic [15:0] b;
    send_item(REQ_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      b = wide ? 16'($urandom) : 16'($urandom_range(12));
      if ($urandom_range(9) == 0) b = 0;
      send_item(REQ_ADD, wide ? 16'($urandom) : 16'($urandom_range(40)), b,
                $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4)));
    end
    for (int i = 0; i < 3 * n + 4; i++) begin
      case ($urandom_range(19))
        0: send_item(REQ_NONE, 16'($urandom), 16'($urandom), 8'($urandom));
        1: send_item(REQ_ADD, 16'($urandom_range(60)), 16'($urandom_range(8)),
                     8'($urandom));
        default: send_item(REQ_DISPATCH, 16'($urandom), 16'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // output side: random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    int unsigned sent;
    board = new();
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_ready_i = 0;
    cfg_valid_i = 0; cfg_data_i = 0; calm = 0; hold_off = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, full table, zero burst, wide index, type three
    send_item(REQ_DISPATCH, 0, 0, 0);
    for (int i = 0; i < DEPTH; i++)
      send_item(REQ_ADD, i == 0 ? 16'hFFFF : i[15:0], i == 1 ? 16'd0 : 16'hFFFF,
                i == 2 ? 8'd0 : (i == 3 ? 8'hFF : i[7:0]));
    send_item(REQ_ADD, 0, 1, 1);
    send_item(REQ_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (4) send_item(REQ_DISPATCH, 0, 0, 0);
    write_base(8'd0);
    send_item(REQ_DISPATCH, 0, 0, 0);
    write_base(8'd255);
    send_item(REQ_DISPATCH, 0, 0, 0);

    // receiver holds off while the sender keeps offering
    hold_off = 300;
    sent = 26;
    while (sent < 1550) begin
      if (sent > 700 && sent < 900) calm = 1; else calm = 0;
      if ($urandom_range(15) == 0) write_base($urandom_range(3) == 0 ? 8'd1 : 8'($urandom));
      run_set($urandom_range(1, DEPTH), $urandom_range(7) == 0);
      sent += 40;
    end
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d run slots (%0d finishing), %0d idle gaps, %0d done, %0d full",
             board.n_run, board.n_fin, board.n_idle, board.n_done, board.n_full);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("fair_share_slot_scheduler regression: pass");
    end else begin
      $display("fair_share_slot_scheduler regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("fair_share_slot_scheduler regression: fail");
    $finish;
  end
endmodule

### files.f
hdl/fss_pkg.sv
hdl/fss_cell.sv
hdl/fss_div.sv
hdl/fair_share_slot_scheduler.sv
dv/tb_fair_share_slot_scheduler.sv
